>>> hdl/edfq_pkg.sv
// shared types and codes for the deadline queue
package edfq_pkg;
    localparam logic [1:0] OP_INSERT   = 2'd0;
    localparam logic [1:0] OP_SCHEDULE = 2'd1;
    localparam logic [1:0] OP_CHECK    = 2'd2;

    localparam logic [1:0] KIND_ACK    = 2'd0;
    localparam logic [1:0] KIND_CANCEL = 2'd1;
    localparam logic [1:0] KIND_HEAD   = 2'd2;
    localparam logic [1:0] KIND_CHECK  = 2'd3;

    typedef struct packed {
        logic [7:0]  id;
        logic [31:0] deadline;
        logic [31:0] latest_start;
        logic [15:0] remaining;
    } job_t;

    // control broadcast to every cell
    typedef struct packed {
        logic insert;
        logic shift_out;
        job_t job;
    } cell_ctrl_t;
endpackage

>>> hdl/edf_deadline_queue_top.sv
// earliest-deadline-first job queue built from a chain of slot cells
// channels: input item (operation, job fields, now_time) with valid/ready,
// result item (result_kind, result_job, job_found, queue_full, last_result)
// with out_valid/out_ready; last_result marks the final result of an item.
// insert: the whole chain compares and shifts in the cycle of acceptance,
// ack in the cycle after. schedule: each cancelled head job gives a cancel
// result (drop shifts the chain by one), then the head report. check: a
// running sum walks each queued job through the head slot, then the report
// is given; the chain rotates back to its original order.
// one item is worked on at a time; a new item is taken only when the block
// is idle and the output register is empty or being read in that cycle.
// when the receiver stalls the output register holds and the work pauses.
// reset empties the queue (all slot valid bits clear) and idles the block.
module edf_deadline_queue_top #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [7:0]  job_id,
    input  logic [31:0] abs_deadline,
    input  logic [31:0] latest_start,
    input  logic [15:0] remaining_time,
    input  logic [31:0] now_time,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  result_kind,
    output logic [7:0]  result_job,
    output logic        job_found,
    output logic        queue_full,
    output logic        last_result
);
    import edfq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCHED = 2'd1;
    localparam logic [1:0] ST_CHECK = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [31:0] now_reg, now_next;
    logic [47:0] sum_reg, sum_next;
    logic [CW-1:0] steps_reg, steps_next;
    logic [CW-1:0] count_reg, count_next;
    logic missed_reg, missed_next;
    logic [7:0] miss_id_reg, miss_id_next;
    logic out_valid_reg, out_valid_next;
    logic [1:0] kind_reg, kind_next;
    logic [7:0] rjob_reg, rjob_next;
    logic found_reg, found_next, full_reg, full_next, last_reg, last_next;

    cell_ctrl_t ctrl;
    logic rotate;
    logic [QUEUE_DEPTH-1:0] cv, cga;
    job_t cj [QUEUE_DEPTH];

    logic out_free, take, full_now;
    logic [47:0] sum_add;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE) && out_free;
    assign take = in_valid && in_ready;
    assign full_now = cv[QUEUE_DEPTH-1];
    assign sum_add = sum_reg + {32'd0, cj[0].remaining};

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++)
        begin : g_cell
            logic pv, pga, nv;
            job_t pj, nj;
            logic nv_eff;
            job_t nj_eff;
            if (g == 0)
            begin : g_first
                assign pv = 1'b1;
                assign pga = 1'b1;
                assign pj = ctrl.job;
            end
            else
            begin : g_mid
                assign pv = cv[g-1];
                assign pga = cga[g-1];
                assign pj = cj[g-1];
            end
            if (g == QUEUE_DEPTH - 1)
            begin : g_last
                assign nv = 1'b0;
                assign nj = cj[0];
            end
            else
            begin : g_inner
                assign nv = cv[g+1];
                assign nj = cj[g+1];
            end
            // during check the head wraps to the tail slot of the filled part
            always_comb
            begin
                nv_eff = nv;
                nj_eff = nj;
                if (rotate && !nv)
                begin
                    nv_eff = cv[g];
                    nj_eff = cj[0];
                end
            end
            edfq_cell u_cell (
                .clk             (clk),
                .rst_n           (rst_n),
                .ctrl            (ctrl),
                .prev_valid      (pv),
                .prev_goes_after (pga),
                .prev_job        (pj),
                .next_valid      (nv_eff),
                .next_job        (nj_eff),
                .valid           (cv[g]),
                .goes_after      (cga[g]),
                .job             (cj[g])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        now_next = now_reg;
        sum_next = sum_reg;
        steps_next = steps_reg;
        count_next = count_reg;
        missed_next = missed_reg;
        miss_id_next = miss_id_reg;
        out_valid_next = out_valid_reg && !out_ready;
        kind_next = kind_reg;
        rjob_next = rjob_reg;
        found_next = found_reg;
        full_next = full_reg;
        last_next = last_reg;
        ctrl.insert = 1'b0;
        ctrl.shift_out = 1'b0;
        ctrl.job.id = job_id;
        ctrl.job.deadline = abs_deadline;
        ctrl.job.latest_start = latest_start;
        ctrl.job.remaining = remaining_time;
        rotate = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    unique case (operation)
                        OP_INSERT:
                        begin
                            ctrl.insert = !full_now;
                            if (!full_now)
                                count_next = count_reg + CW'(1);
                            out_valid_next = 1'b1;
                            kind_next = KIND_ACK;
                            rjob_next = job_id;
                            found_next = 1'b0;
                            full_next = full_now;
                            last_next = 1'b1;
                        end
                        OP_SCHEDULE:
                        begin
                            now_next = now_time;
                            state_next = ST_SCHED;
                        end
                        OP_CHECK:
                        begin
                            sum_next = {16'd0, now_time};
                            steps_next = '0;
                            missed_next = 1'b0;
                            miss_id_next = 8'd0;
                            state_next = ST_CHECK;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCHED:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    full_next = 1'b0;
                    if (cv[0] && (cj[0].latest_start < now_reg))
                    begin
                        ctrl.shift_out = 1'b1;
                        count_next = count_reg - CW'(1);
                        kind_next = KIND_CANCEL;
                        rjob_next = cj[0].id;
                        found_next = 1'b1;
                        last_next = 1'b0;
                    end
                    else
                    begin
                        kind_next = KIND_HEAD;
                        rjob_next = cv[0] ? cj[0].id : 8'd0;
                        found_next = cv[0];
                        last_next = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_CHECK:
            begin
                if (steps_reg != count_reg)
                begin
                    ctrl.shift_out = 1'b1;
                    rotate = 1'b1;
                    sum_next = sum_add;
                    steps_next = steps_reg + CW'(1);
                    if (!missed_reg && sum_add > {16'd0, cj[0].deadline})
                    begin
                        missed_next = 1'b1;
                        miss_id_next = cj[0].id;
                    end
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next = KIND_CHECK;
                    rjob_next = miss_id_reg;
                    found_next = missed_reg;
                    full_next = 1'b0;
                    last_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg <= now_next;
        sum_reg <= sum_next;
        steps_reg <= steps_next;
        missed_reg <= missed_next;
        miss_id_reg <= miss_id_next;
        kind_reg <= kind_next;
        rjob_reg <= rjob_next;
        found_reg <= found_next;
        full_reg <= full_next;
        last_reg <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign result_kind = kind_reg;
    assign result_job = rjob_reg;
    assign job_found = found_reg;
    assign queue_full = full_reg;
    assign last_result = last_reg;
endmodule

>>> hdl/edfq_cell.sv
// one queue slot: holds a job, takes insert or shift from its neighbors
module edfq_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  edfq_pkg::cell_ctrl_t ctrl,
    input  logic              prev_valid,
    input  logic              prev_goes_after,
    input  edfq_pkg::job_t    prev_job,
    input  logic              next_valid,
    input  edfq_pkg::job_t    next_job,
    output logic              valid,
    output logic              goes_after,
    output edfq_pkg::job_t    job
);
    import edfq_pkg::*;

    logic valid_reg;
    logic valid_next;
    job_t job_reg;
    job_t job_next;

    // new job goes behind this one when deadline is not later
    assign goes_after = valid_reg && (job_reg.deadline <= ctrl.job.deadline);
    assign valid = valid_reg;
    assign job = job_reg;

    always_comb
    begin
        valid_next = valid_reg;
        job_next = job_reg;
        if (ctrl.insert)
        begin
            if (!goes_after)
            begin
                valid_next = valid_reg || prev_valid;
                if (prev_goes_after)
                    job_next = ctrl.job;
                else
                    job_next = prev_job;
            end
        end
        else if (ctrl.shift_out)
        begin
            valid_next = next_valid;
            job_next = next_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end
endmodule
